@@ hw/rtl/mrm_pkg.sv @@
// Shared types, codes, constants and the CRC-16 step of the Modbus RTU master.
package mrm_pkg;

    // Default register limit of a read request.
    localparam int MRM_MAX_REGS = 16;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [15:0] CRC_SEED      = 16'hFFFF;
    localparam logic [7:0]  EXC_FLAG      = 8'h80;
    localparam logic [7:0]  FC_READ_HOLD  = 8'd3;
    localparam logic [7:0]  FC_READ_INPUT = 8'd4;
    localparam logic [7:0]  FC_WRITE_ONE  = 8'd6;
    localparam int          EXC_LEN       = 5;
    localparam int          WRITE_LEN     = 8;

    // Input beat kinds.
    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_RX    = 2'd2,
        CMD_TICK  = 2'd3
    } cmd_code_t;

    // Result beat kinds.
    typedef enum logic [1:0] {
        KIND_REQ    = 2'd0,
        KIND_PAY    = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    // Transaction status codes.
    typedef enum logic [3:0] {
        STS_OK        = 4'd0,
        STS_BAD_PARAM = 4'd1,
        STS_BUS_OFF   = 4'd2,
        STS_NO_RESP   = 4'd3,
        STS_SHORT     = 4'd4,
        STS_CRC       = 4'd5,
        STS_OTHER_SLV = 4'd6,
        STS_OTHER_FC  = 4'd7,
        STS_EXCEPTION = 4'd8,
        STS_MISMATCH  = 4'd9
    } status_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_REQ,
        S_WAIT,
        S_EVAL,
        S_PAYRD,
        S_PAYOUT,
        S_STAT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_start;
        logic early_emit;
        logic req_emit;
        logic rx_byte;
        logic tick;
        logic eval;
        logic pay_rd;
        logic pay_emit;
        logic stat_emit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic early_bad;
        logic req_last;
        logic rx_done;
        logic timeout;
        logic eval_pay;
        logic pay_last;
    } dp_sts_t;

    // One byte through the reflected CRC-16, bit by bit.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/mrm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 37
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/mrm_ctrl.sv @@
// Transaction controller state machine of the Modbus RTU master.
module mrm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [1:0]       s_tuser,
    output mrm_pkg::dp_cmd_t cmd,
    input  mrm_pkg::dp_sts_t sts
);
    import mrm_pkg::*;

    state_t    state_reg;
    state_t    state_next;
    cmd_code_t code;
    logic      accept;
    logic      waiting;

    assign code    = cmd_code_t'(s_tuser);
    assign waiting = (state_reg == S_WAIT);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        accept     = 1'b0;
        case (state_reg)
            S_IDLE, S_WAIT:
            begin
                s_tready = sts.out_free;
                accept   = s_tvalid && sts.out_free;
                if (accept)
                begin
                    case (code)
                        CMD_READ, CMD_WRITE:
                        begin
                            cmd.load_start = 1'b1;
                            if (sts.early_bad)
                            begin
                                cmd.early_emit = 1'b1;
                                state_next     = S_IDLE;
                            end
                            else
                            begin
                                state_next = S_REQ;
                            end
                        end
                        CMD_RX:
                        begin
                            if (waiting)
                            begin
                                cmd.rx_byte = 1'b1;
                                if (sts.rx_done)
                                begin
                                    state_next = S_EVAL;
                                end
                            end
                        end
                        CMD_TICK:
                        begin
                            if (waiting)
                            begin
                                cmd.tick = 1'b1;
                                if (sts.timeout)
                                begin
                                    state_next = S_EVAL;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = state_reg;
                        end
                    endcase
                end
            end
            S_REQ:
            begin
                if (sts.out_free)
                begin
                    cmd.req_emit = 1'b1;
                    if (sts.req_last)
                    begin
                        state_next = S_WAIT;
                    end
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = sts.eval_pay ? S_PAYRD : S_STAT;
            end
            S_PAYRD:
            begin
                cmd.pay_rd = 1'b1;
                state_next = S_PAYOUT;
            end
            S_PAYOUT:
            begin
                if (sts.out_free)
                begin
                    cmd.pay_emit = 1'b1;
                    state_next   = sts.pay_last ? S_STAT : S_PAYRD;
                end
            end
            S_STAT:
            begin
                if (sts.out_free)
                begin
                    cmd.stat_emit = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // A payload beat always follows its RAM read.
    a_payout_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PAYOUT) |-> ($past(state_reg) == S_PAYRD || $past(state_reg) == S_PAYOUT))
        else $error("payload output without a preceding read");

    // At most one result is loaded per cycle.
    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.req_emit, cmd.pay_emit, cmd.stat_emit, cmd.early_emit}))
        else $error("several result loads in one cycle");

    // A result is loaded only into a free output register.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.req_emit || cmd.pay_emit || cmd.stat_emit || cmd.early_emit) |-> sts.out_free)
        else $error("result loaded over a pending beat");

endmodule

@@ hw/rtl/mrm_dp.sv @@
// Datapath of the Modbus RTU master: request, receive buffer, CRC, checks, output register.
module mrm_dp #(
    parameter int MAX_REGS = mrm_pkg::MRM_MAX_REGS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [71:0]      s_tdata,
    input  logic [1:0]       s_tuser,
    input  logic             cfg_valid,
    input  logic [15:0]      cfg_data,
    input  mrm_pkg::dp_cmd_t cmd,
    output mrm_pkg::dp_sts_t sts,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);
    import mrm_pkg::*;

    localparam int RX_DEPTH = 5 + 2 * MAX_REGS + 4;
    localparam int LEN_W    = $clog2(RX_DEPTH + 1);
    localparam int ADDR_W   = $clog2(RX_DEPTH);

    // Input fields.
    logic [7:0]  in_sla;
    logic [7:0]  in_fc;
    logic [15:0] in_reg;
    logic [7:0]  in_cnt;
    logic [15:0] in_val;
    logic [7:0]  in_rx;
    logic        in_pwr;
    logic        is_read;

    assign in_sla  = s_tdata[7:0];
    assign in_fc   = s_tdata[15:8];
    assign in_reg  = s_tdata[31:16];
    assign in_cnt  = s_tdata[39:32];
    assign in_val  = s_tdata[55:40];
    assign in_rx   = s_tdata[63:56];
    assign in_pwr  = s_tdata[64];
    assign is_read = (cmd_code_t'(s_tuser) == CMD_READ);

    // Registers.
    logic [15:0]       timeout_reg;
    logic [7:0]        req_reg [6];
    logic [7:0]        cnt_reg;
    logic [LEN_W-1:0]  exp_reg;
    logic [LEN_W-1:0]  rx_len_reg;
    logic [15:0]       elapsed_reg;
    logic [15:0]       crc_reg;
    logic [7:0]        p0_reg;
    logic [7:0]        p1_reg;
    logic [7:0]        rb_reg [6];
    logic [2:0]        idx_reg;
    logic [LEN_W-1:0]  pidx_reg;
    logic [LEN_W-1:0]  pend_reg;
    status_t           ev_st_reg;
    logic [7:0]        ev_exc_reg;
    logic [5:0]        ev_pc_reg;
    logic              out_valid_reg;
    kind_t             out_kind_reg;
    logic [7:0]        out_byte_reg;
    status_t           out_st_reg;
    logic [7:0]        out_exc_reg;
    logic [5:0]        out_pc_reg;
    logic              out_last_reg;

    // Start checks.
    logic param_bad;
    assign param_bad = is_read && (in_cnt == 8'd0 || in_cnt > 8'(MAX_REGS) ||
                       (in_fc != FC_READ_HOLD && in_fc != FC_READ_INPUT));

    // Request byte selection.
    logic [7:0] req_byte;
    always_comb
    begin
        case (idx_reg)
            3'd6:    req_byte = crc_reg[7:0];
            3'd7:    req_byte = crc_reg[15:8];
            default: req_byte = req_reg[idx_reg];
        endcase
    end

    // Receive byte handling.
    logic             rx_drop;
    logic             rx_take;
    logic [LEN_W-1:0] rx_len_inc;
    logic             rx_done;
    assign rx_drop    = (rx_len_reg == '0) && (in_rx != req_reg[0]);
    assign rx_take    = cmd.rx_byte && !rx_drop && (rx_len_reg < LEN_W'(RX_DEPTH));
    assign rx_len_inc = rx_len_reg + 1'b1;
    assign rx_done    = !rx_drop && ((rx_len_inc >= LEN_W'(EXC_LEN) && rb_reg[1][7]) ||
                        rx_len_inc >= exp_reg);

    // Tick handling.
    logic [15:0] elapsed_inc;
    assign elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;

    // Frame checks, in priority order.
    status_t    ev_st;
    logic [7:0] ev_exc;
    logic [8:0] bc_ext;
    logic [8:0] len_ext;
    assign bc_ext  = {1'b0, rb_reg[2]};
    assign len_ext = 9'(rx_len_reg);
    always_comb
    begin
        ev_exc = 8'd0;
        if (rx_len_reg == '0)
        begin
            ev_st = STS_NO_RESP;
        end
        else if (rx_len_reg < LEN_W'(EXC_LEN))
        begin
            ev_st = STS_SHORT;
        end
        else if ({p1_reg, p0_reg} != crc_reg)
        begin
            ev_st = STS_CRC;
        end
        else if (rb_reg[0] != req_reg[0])
        begin
            ev_st = STS_OTHER_SLV;
        end
        else if (rb_reg[1] == (req_reg[1] | EXC_FLAG))
        begin
            ev_st  = STS_EXCEPTION;
            ev_exc = rb_reg[2];
        end
        else if (rb_reg[1] != req_reg[1])
        begin
            ev_st = STS_OTHER_FC;
        end
        else if (req_reg[1] == FC_WRITE_ONE)
        begin
            if (rx_len_reg < LEN_W'(WRITE_LEN) || rb_reg[2] != req_reg[2] ||
                rb_reg[3] != req_reg[3] || rb_reg[4] != req_reg[4] || rb_reg[5] != req_reg[5])
            begin
                ev_st = STS_MISMATCH;
            end
            else
            begin
                ev_st = STS_OK;
            end
        end
        else if (bc_ext != {cnt_reg, 1'b0} || bc_ext + 9'd5 > len_ext)
        begin
            ev_st = STS_MISMATCH;
        end
        else
        begin
            ev_st = STS_OK;
        end
    end

    logic ev_pay;
    assign ev_pay = (ev_st == STS_OK) && (req_reg[1] != FC_WRITE_ONE);

    // Receive buffer.
    logic [7:0] ram_rdata;
    mrm_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_take),
        .waddr (rx_len_reg[ADDR_W-1:0]),
        .wdata (in_rx),
        .re    (cmd.pay_rd),
        .raddr (ADDR_W'(pidx_reg + LEN_W'(3))),
        .rdata (ram_rdata)
    );

    // Transaction state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            for (int k = 0; k < 6; k++)
            begin
                req_reg[k] <= 8'd0;
                rb_reg[k]  <= 8'd0;
            end
            cnt_reg     <= 8'd0;
            exp_reg     <= '0;
            rx_len_reg  <= '0;
            elapsed_reg <= 16'd0;
            crc_reg     <= CRC_SEED;
            p0_reg      <= 8'd0;
            p1_reg      <= 8'd0;
            idx_reg     <= 3'd0;
            pidx_reg    <= '0;
            pend_reg    <= '0;
            ev_st_reg   <= STS_OK;
            ev_exc_reg  <= 8'd0;
            ev_pc_reg   <= 6'd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                timeout_reg <= cfg_data;
            end
            // Start: clear the receive side and latch the request if it passes the checks.
            if (cmd.load_start)
            begin
                rx_len_reg  <= '0;
                elapsed_reg <= 16'd0;
                crc_reg     <= CRC_SEED;
                idx_reg     <= 3'd0;
                if (!(param_bad || !in_pwr))
                begin
                    req_reg[0] <= in_sla;
                    req_reg[1] <= is_read ? in_fc : FC_WRITE_ONE;
                    req_reg[2] <= in_reg[15:8];
                    req_reg[3] <= in_reg[7:0];
                    req_reg[4] <= is_read ? 8'd0 : in_val[15:8];
                    req_reg[5] <= is_read ? in_cnt : in_val[7:0];
                    cnt_reg    <= is_read ? in_cnt : 8'd0;
                    exp_reg    <= is_read ? LEN_W'(9'd5 + {in_cnt, 1'b0}) : LEN_W'(WRITE_LEN);
                end
            end
            // Request bytes: CRC over the first six, then its two bytes.
            if (cmd.req_emit)
            begin
                idx_reg <= idx_reg + 3'd1;
                if (idx_reg == 3'd7)
                begin
                    crc_reg <= CRC_SEED;
                end
                else if (idx_reg < 3'd6)
                begin
                    crc_reg <= crc_feed(crc_reg, req_byte);
                end
            end
            // Received byte: the CRC runs two bytes behind the newest one.
            if (rx_take)
            begin
                rx_len_reg <= rx_len_inc;
                p0_reg     <= p1_reg;
                p1_reg     <= in_rx;
                if (rx_len_reg >= LEN_W'(2))
                begin
                    crc_reg <= crc_feed(crc_reg, p0_reg);
                end
                for (int k = 0; k < 6; k++)
                begin
                    if (rx_len_reg == LEN_W'(k))
                    begin
                        rb_reg[k] <= in_rx;
                    end
                end
            end
            if (cmd.tick)
            begin
                elapsed_reg <= elapsed_inc;
            end
            // Latch the verdict.
            if (cmd.eval)
            begin
                ev_st_reg  <= ev_st;
                ev_exc_reg <= ev_exc;
                ev_pc_reg  <= ev_pay ? rb_reg[2][5:0] : 6'd0;
                pend_reg   <= LEN_W'(rb_reg[2] - 8'd1);
                pidx_reg   <= '0;
            end
            if (cmd.pay_emit)
            begin
                pidx_reg <= pidx_reg + 1'b1;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_kind_reg  <= KIND_REQ;
            out_byte_reg  <= 8'd0;
            out_st_reg    <= STS_OK;
            out_exc_reg   <= 8'd0;
            out_pc_reg    <= 6'd0;
            out_last_reg  <= 1'b0;
        end
        else if (cmd.req_emit || cmd.pay_emit || cmd.stat_emit || cmd.early_emit)
        begin
            out_valid_reg <= 1'b1;
            out_kind_reg  <= cmd.req_emit ? KIND_REQ : (cmd.pay_emit ? KIND_PAY : KIND_STATUS);
            out_byte_reg  <= cmd.req_emit ? req_byte : (cmd.pay_emit ? ram_rdata : 8'd0);
            out_st_reg    <= cmd.stat_emit ? ev_st_reg :
                             (cmd.early_emit ? (param_bad ? STS_BAD_PARAM : STS_BUS_OFF) : STS_OK);
            out_exc_reg   <= cmd.stat_emit ? ev_exc_reg : 8'd0;
            out_pc_reg    <= cmd.stat_emit ? ev_pc_reg : 6'd0;
            out_last_reg  <= cmd.stat_emit || cmd.early_emit;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'd0, out_pc_reg, out_exc_reg, out_st_reg, out_byte_reg};

    // Status to the controller.
    always_comb
    begin
        sts.out_free  = !out_valid_reg || m_tready;
        sts.early_bad = param_bad || !in_pwr;
        sts.req_last  = (idx_reg == 3'd7);
        sts.rx_done   = rx_done;
        sts.timeout   = (elapsed_inc >= timeout_reg);
        sts.eval_pay  = ev_pay;
        sts.pay_last  = (pidx_reg == pend_reg);
    end

    // The fill count never passes the buffer depth.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rx_len_reg <= LEN_W'(RX_DEPTH))
        else $error("receive count beyond buffer depth");

    // Only a status beat closes a run.
    a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tuser == KIND_STATUS))
        else $error("last flag on a byte beat");

    // A payload count appears only with an ok status.
    a_pc_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_pc_reg != 6'd0) |-> (out_st_reg == STS_OK))
        else $error("payload count on a failed transaction");

endmodule

@@ hw/rtl/modbus_rtu_master_transaction_top.sv @@
// Top level of the Modbus RTU master transaction engine.
//
//  Channel  Dir  Signals                       Content
//  s_*      in   tvalid tready tdata tuser     command beats (start, rx byte, tick)
//  m_*      out  tvalid tready tdata tuser     request bytes, payload bytes, status
//                tlast
//  cfg_*    in   valid ready data              timeout_ticks register
//
// A start that passes its checks is followed by 8 request beats, one per cycle
// while the output is free, and the input is held off meanwhile.
// A finished frame passes a check state, then for a good read reply each payload
// byte takes a buffer RAM read, then an output load, and last comes the status beat.
// A stalled output register holds off the input until it is taken.
// Reset clears the controller to idle and the timeout register to 1000 ticks.
module modbus_rtu_master_transaction_top #(
    parameter int MAX_REGS = mrm_pkg::MRM_MAX_REGS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // slave_addr, function_code, register_addr, register_count, write_value,
    // rx_data, bus_powered (from bit 0 up)
    input  logic [71:0] s_tdata,
    // command
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // byte_value, status, exception_code, payload_count (from bit 0 up)
    output logic [31:0] m_tdata,
    // kind
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import mrm_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    // Controller.
    mrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Datapath.
    mrm_dp #(
        .MAX_REGS (MAX_REGS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
